// File: rtl/assert_macros.svh
// Assertion macros used by the checker file mtx_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// File: rtl/mtx_pkg.sv
// Shared types and codes for the mutex table.
`default_nettype none

package mtx_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 4;
  localparam int PIDF_W = 16;
  localparam int ST_W = 3;
  localparam int ACT_W = 3;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TERM   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EXISTS    = 3'd1;
  localparam logic [ST_W-1:0] ST_MISSING   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_OWNER = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  // Table update selected by the controller
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GRANT   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PUSH    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_HANDOFF = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd5;
  localparam logic [ACT_W-1:0] ACT_TERM    = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  mutex_index;
    logic [PIDF_W-1:0] pid;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              acquired;
    logic              wake_valid;
    logic [PIDF_W-1:0] wake_pid;
  } rsp_t;

  typedef struct packed {
    logic             capture;
    logic             q_read;
    logic             finish;
    logic [ACT_W-1:0] act;
    logic [ST_W-1:0]  status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_range;
    logic             exists;
    logic             locked;
    logic             owner_match;
    logic             q_empty;
    logic             q_full;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/mtx_ctrl.sv
// Command sequencer for the mutex table.
`default_nettype none

module mtx_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire mtx_pkg::dp_stat_t  stat,
  output mtx_pkg::ctrl_cmd_t      ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SLOT  = 2'd1;
  localparam logic [1:0] S_QUEUE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       need_q;

  logic [mtx_pkg::ACT_W-1:0] act;
  logic [mtx_pkg::ST_W-1:0]  status;
  logic                      capture;
  logic                      q_read;
  logic                      finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  assign ctl = '{capture: capture, q_read: q_read, finish: finish, act: act, status: status};

  // Decision on the slot record read for the current command; in S_QUEUE it forces a hand-off
  always_comb begin
    need_q = 1'b0;
    act = mtx_pkg::ACT_NONE;
    status = mtx_pkg::ST_OK;
    if (!stat.in_range) begin
      status = mtx_pkg::ST_MISSING;
    end else if (stat.cmd == mtx_pkg::CMD_CREATE) begin
      if (stat.exists) begin
        status = mtx_pkg::ST_EXISTS;
      end else begin
        act = mtx_pkg::ACT_CREATE;
      end
    end else if (!stat.exists) begin
      status = mtx_pkg::ST_MISSING;
    end else begin
      case (stat.cmd)
        mtx_pkg::CMD_LOCK: begin
          if (!stat.locked) begin
            act = mtx_pkg::ACT_GRANT;
          end else if (stat.q_full) begin
            status = mtx_pkg::ST_FULL;
          end else begin
            act = mtx_pkg::ACT_PUSH;
          end
        end
        mtx_pkg::CMD_UNLOCK: begin
          if (!stat.owner_match) begin
            status = mtx_pkg::ST_NOT_OWNER;
          end else if (stat.locked && !stat.q_empty) begin
            act = mtx_pkg::ACT_HANDOFF;
            need_q = 1'b1;
          end else begin
            act = mtx_pkg::ACT_RELEASE;
          end
        end
        default: begin
          act = mtx_pkg::ACT_TERM;
        end
      endcase
    end
    if (state == S_QUEUE) begin
      act = mtx_pkg::ACT_HANDOFF;
      status = mtx_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    capture = 1'b0;
    q_read = 1'b0;
    finish = 1'b0;
    unique case (state)
      S_IDLE: begin
        capture = cmd_valid;
        if (cmd_valid) begin
          state_next = S_SLOT;
        end
      end
      S_SLOT: begin
        if (need_q) begin
          q_read = 1'b1;
          state_next = S_QUEUE;
        end else if (stat.out_free) begin
          finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_QUEUE: begin
        if (stat.out_free) begin
          finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mtx_dp.sv
// Slot table, wait-queue memory and response register.
`default_nettype none

module mtx_dp #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned PID_WIDTH   = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mtx_pkg::cmd_t       cmd_data,
  input  wire mtx_pkg::ctrl_cmd_t  ctl,
  output mtx_pkg::dp_stat_t        stat,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output mtx_pkg::rsp_t            rsp_data
);

  localparam int SLOT_W = $clog2(NUM_MUTEXES);
  localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int AW     = $clog2(NUM_MUTEXES * QUEUE_DEPTH);
  localparam int WAIT_N = NUM_MUTEXES * QUEUE_DEPTH;

  typedef struct packed {
    logic                 locked;
    logic [PID_WIDTH-1:0] owner;
    logic [QW-1:0]        head;
    logic [CW-1:0]        count;
  } slot_rec_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [mtx_pkg::IDX_W-1:0] i);
    logic [SLOT_W+mtx_pkg::IDX_W-1:0] w;
    w = {SLOT_W'(0), i};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [AW-1:0] wait_addr(input logic [SLOT_W-1:0] s,
                                              input logic [QW-1:0] p);
    return AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  slot_rec_t            slot_mem [NUM_MUTEXES];
  logic [PID_WIDTH-1:0] wait_mem [WAIT_N];

  logic [NUM_MUTEXES-1:0] exists;
  mtx_pkg::cmd_t          item;
  slot_rec_t              rec;
  slot_rec_t              rec_next;
  logic                   rec_we;
  logic [PID_WIDTH-1:0]   qdata;

  logic [SLOT_W-1:0]               slot;
  logic [PID_WIDTH+mtx_pkg::PIDF_W-1:0] pid_ext;
  logic [PID_WIDTH-1:0]            pid_w;
  logic [mtx_pkg::PIDF_W+PID_WIDTH-1:0] wake_ext;
  logic [CW:0]                     tail_sum;
  logic [QW-1:0]                   tail;
  logic [QW:0]                     head_inc;
  logic [QW-1:0]                   head_next;
  logic                            push_we;

  assign slot    = to_slot(item.mutex_index);
  assign pid_ext = {PID_WIDTH'(0), item.pid};
  assign pid_w   = pid_ext[PID_WIDTH-1:0];
  assign wake_ext = {mtx_pkg::PIDF_W'(0), qdata};

  // Ring positions: one compare-subtract each
  assign tail_sum = (CW+1)'(rec.head) + (CW+1)'(rec.count);
  assign tail = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                QW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
  assign head_inc = (QW+1)'(rec.head) + (QW+1)'(1);
  assign head_next = (head_inc == (QW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[QW-1:0];

  always_comb begin
    stat.cmd         = item.command;
    stat.in_range    = (32'(item.mutex_index) < NUM_MUTEXES);
    stat.exists      = stat.in_range && exists[slot];
    stat.locked      = rec.locked;
    stat.owner_match = (rec.owner == pid_w);
    stat.q_empty     = (rec.count == '0);
    stat.q_full      = (rec.count == CW'(QUEUE_DEPTH));
    stat.out_free    = !rsp_valid || rsp_ready;
  end

  always_comb begin
    rec_next = rec;
    rec_we = 1'b0;
    case (ctl.act)
      mtx_pkg::ACT_CREATE: begin
        rec_next.locked = 1'b0;
        rec_next.owner  = '1;
        rec_next.head   = '0;
        rec_next.count  = '0;
        rec_we = 1'b1;
      end
      mtx_pkg::ACT_GRANT: begin
        rec_next.locked = 1'b1;
        rec_next.owner  = pid_w;
        rec_we = 1'b1;
      end
      mtx_pkg::ACT_PUSH: begin
        rec_next.count = rec.count + CW'(1);
        rec_we = 1'b1;
      end
      mtx_pkg::ACT_HANDOFF: begin
        rec_next.owner = qdata;
        rec_next.head  = head_next;
        rec_next.count = rec.count - CW'(1);
        rec_we = 1'b1;
      end
      mtx_pkg::ACT_RELEASE: begin
        rec_next.locked = 1'b0;
        rec_we = 1'b1;
      end
      default: begin
        rec_we = 1'b0;
      end
    endcase
  end

  assign push_we = ctl.finish && (ctl.act == mtx_pkg::ACT_PUSH);

  // Slot records: read on capture, written back when the command finishes
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= cmd_data;
      rec  <= slot_mem[to_slot(cmd_data.mutex_index)];
    end
    if (ctl.finish && rec_we) begin
      slot_mem[slot] <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      wait_mem[wait_addr(slot, tail)] <= pid_w;
    end
    if (ctl.q_read) begin
      qdata <= wait_mem[wait_addr(slot, rec.head)];
    end
  end

  // Existence flags double as valid bits for the slot records
  always_ff @(posedge clk) begin
    if (rst) begin
      exists <= '0;
    end else if (ctl.finish && ctl.act == mtx_pkg::ACT_CREATE) begin
      exists[slot] <= 1'b1;
    end else if (ctl.finish && ctl.act == mtx_pkg::ACT_TERM) begin
      exists[slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      rsp_data.status     <= ctl.status;
      rsp_data.acquired   <= (ctl.act == mtx_pkg::ACT_GRANT);
      rsp_data.wake_valid <= (ctl.act == mtx_pkg::ACT_HANDOFF);
      rsp_data.wake_pid   <= (ctl.act == mtx_pkg::ACT_HANDOFF) ?
                             wake_ext[mtx_pkg::PIDF_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mutex_table_with_wait_queues.sv
// The response follows the registered slot-record read and, for a wake-up unlock, the
//   dependent wait-queue memory read; a new command is taken only once the last finishes.
//   A command does not finish while the response register is still held by the receiver.
// A finished response waits in its own register while the next command is taken.
// Reset clears the existence flags, controller and response valid; slot records and
//   queue entries are not cleared (create writes a fresh record), so no clearing pass.
`default_nettype none

module mutex_table_with_wait_queues #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned PID_WIDTH   = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire mtx_pkg::cmd_t  cmd_data,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output mtx_pkg::rsp_t       rsp_data
);

  mtx_pkg::ctrl_cmd_t ctl;
  mtx_pkg::dp_stat_t  stat;

  mtx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  mtx_dp #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_WIDTH   (PID_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_data),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

`default_nettype wire

// File: rtl/mtx_checker.sv
// Port-level checks for the mutex table, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module mtx_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cmd_valid,
  input wire logic           cmd_ready,
  input wire mtx_pkg::cmd_t  cmd_data,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire mtx_pkg::rsp_t  rsp_data
);

  logic rsp_ok;
  logic wake_clean;

  assign rsp_ok = (rsp_data.status == mtx_pkg::ST_OK);
  assign wake_clean = rsp_data.wake_valid ? rsp_ok : (rsp_data.wake_pid == '0);

  // Pending command stays put until its transfer
  `ASSERT_NEXT(a_cmd_hold, clk, rst, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd_data))

  // Stalled response stays put
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

  // A command transfer is always followed by cmd_ready going low
  `ASSERT_NEXT(a_cmd_gap, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // A grant is a clean success with no wake-up
  `ASSERT_IMPL(a_grant_ok, clk, rst, rsp_valid && rsp_data.acquired, rsp_ok && !rsp_data.wake_valid)

  // Wake pid is zero unless a hand-off happened, and a hand-off is ok
  `ASSERT_IMPL(a_wake_clean, clk, rst, rsp_valid, wake_clean)

endmodule

bind mutex_table_with_wait_queues mtx_checker u_mtx_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd_data  (cmd_data),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

`default_nettype wire

// File: test/tb_mutex_table_with_wait_queues.sv
// Testbench for the mutex table: directed table plus random traffic checked by a predictor.
`timescale 1ns / 1ps

module tb_mutex_table_with_wait_queues;

  localparam int NUM_SLOTS = 16;
  localparam int Q_DEPTH   = 8;
  localparam logic [15:0] NO_OWNER = 16'hFFFF;

  typedef struct packed {
    mtx_pkg::cmd_t cmd;
    logic          pinned;
    mtx_pkg::rsp_t rsp;
  } dir_row_t;

  logic          clk;
  logic          rst;
  logic          cmd_valid;
  logic          cmd_ready;
  mtx_pkg::cmd_t cmd_data;
  logic          rsp_valid;
  logic          rsp_ready;
  mtx_pkg::rsp_t rsp_data;

  mutex_table_with_wait_queues dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // Shadow of the slot table
  logic        slot_live  [NUM_SLOTS];
  logic        slot_held  [NUM_SLOTS];
  logic [15:0] slot_owner [NUM_SLOTS];
  logic [15:0] waiters    [NUM_SLOTS][Q_DEPTH];
  logic [2:0]  q_head     [NUM_SLOTS];
  logic [3:0]  q_count    [NUM_SLOTS];

  mtx_pkg::rsp_t awaited_rsp[$];
  dir_row_t      dir_rows[$];
  mtx_pkg::rsp_t want;
  int            mismatch_count = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void drop_slot(input logic [3:0] s);
    slot_live[s]  = 1'b0;
    slot_held[s]  = 1'b0;
    slot_owner[s] = NO_OWNER;
    q_head[s]     = '0;
    q_count[s]    = '0;
  endfunction

  // Applies one command to the shadow table and returns the reply it should get.
  // The 4-bit index cannot address beyond a 16-entry table.
  function automatic mtx_pkg::rsp_t apply_mutex_cmd(input mtx_pkg::cmd_t c);
    mtx_pkg::rsp_t r;
    logic [3:0]    s;
    logic [15:0]   woken;
    r = '0;
    r.status = mtx_pkg::ST_OK;
    s = c.mutex_index;
    if (c.command == mtx_pkg::CMD_CREATE) begin
      if (slot_live[s]) begin
        r.status = mtx_pkg::ST_EXISTS;
      end else begin
        drop_slot(s);
        slot_live[s] = 1'b1;
      end
    end else if (!slot_live[s]) begin
      r.status = mtx_pkg::ST_MISSING;
    end else if (c.command == mtx_pkg::CMD_LOCK) begin
      if (!slot_held[s]) begin
        slot_held[s]  = 1'b1;
        slot_owner[s] = c.pid;
        r.acquired    = 1'b1;
      end else if (q_count[s] == 4'(Q_DEPTH)) begin
        r.status = mtx_pkg::ST_FULL;
      end else begin
        waiters[s][3'(q_head[s] + q_count[s])] = c.pid;
        q_count[s] = q_count[s] + 4'd1;
      end
    end else if (c.command == mtx_pkg::CMD_UNLOCK) begin
      if (slot_owner[s] != c.pid) begin
        r.status = mtx_pkg::ST_NOT_OWNER;
      end else if (slot_held[s] && q_count[s] != 0) begin
        woken         = waiters[s][q_head[s]];
        r.wake_valid  = 1'b1;
        r.wake_pid    = woken;
        slot_owner[s] = woken;
        q_head[s]     = q_head[s] + 3'd1;
        q_count[s]    = q_count[s] - 4'd1;
      end else begin
        // free mutex keeps its previous owner on record
        slot_held[s] = 1'b0;
      end
    end else begin
      drop_slot(s);
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] op, input logic [3:0] s,
                                      input logic [15:0] p, input logic pinned,
                                      input logic [2:0] st, input logic acq);
    dir_row_t row;
    row.cmd.command     = op;
    row.cmd.mutex_index = s;
    row.cmd.pid         = p;
    row.pinned          = pinned;
    row.rsp             = '0;
    row.rsp.status      = st;
    row.rsp.acquired    = acq;
    return row;
  endfunction

  function automatic logic [15:0] pick_pid();
    case ($urandom_range(0, 9))
      0: return 16'h0001;
      1: return 16'h00FF;
      2: return 16'h8000;
      3: return NO_OWNER;
      4: return 16'h7FFE;
      5: return 16'h1234;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly well-formed traffic on a few slots so queues fill and drain.
  function automatic mtx_pkg::cmd_t pick_random_cmd();
    mtx_pkg::cmd_t c;
    int            roll;
    c.mutex_index = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 3))
                                               : 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (!slot_live[c.mutex_index] && roll < 60) begin
      c.command = mtx_pkg::CMD_CREATE;
    end else if (roll < 7) begin
      c.command = mtx_pkg::CMD_CREATE;
    end else if (roll < 62) begin
      c.command = mtx_pkg::CMD_LOCK;
    end else if (roll < 95) begin
      c.command = mtx_pkg::CMD_UNLOCK;
    end else begin
      c.command = mtx_pkg::CMD_TERM;
    end
    if (c.command == mtx_pkg::CMD_UNLOCK && $urandom_range(0, 3) != 0) begin
      c.pid = slot_owner[c.mutex_index];
    end else begin
      c.pid = pick_pid();
    end
    return c;
  endfunction

  task automatic issue_cmd(input mtx_pkg::cmd_t c, input logic pinned,
                           input mtx_pkg::rsp_t pinned_rsp);
    mtx_pkg::rsp_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    do @(posedge clk); while (!cmd_ready);
    predicted = apply_mutex_cmd(c);
    awaited_rsp.push_back(pinned ? pinned_rsp : predicted);
  endtask

  task automatic drain_replies();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected reply %p", $time, rsp_data);
        mismatch_count++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp_data.status);
          mismatch_count++;
        end
        if (rsp_data.acquired !== want.acquired) begin
          $display("%0t: acquired expected %0d got %0d", $time, want.acquired,
                   rsp_data.acquired);
          mismatch_count++;
        end
        if (rsp_data.wake_valid !== want.wake_valid) begin
          $display("%0t: wake_valid expected %0d got %0d", $time, want.wake_valid,
                   rsp_data.wake_valid);
          mismatch_count++;
        end
        if (rsp_data.wake_pid !== want.wake_pid) begin
          $display("%0t: wake_pid expected %h got %h", $time, want.wake_pid,
                   rsp_data.wake_pid);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    rsp_ready = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) drop_slot(4'(s));

    dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd0, 16'h0001, 1'b1,
                              mtx_pkg::ST_MISSING, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd15, NO_OWNER, 1'b1,
                              mtx_pkg::ST_MISSING, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_TERM, 4'd3, 16'h0000, 1'b1,
                              mtx_pkg::ST_MISSING, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_CREATE, 4'd0, 16'h0000, 1'b1,
                              mtx_pkg::ST_OK, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_CREATE, 4'd0, NO_OWNER, 1'b1,
                              mtx_pkg::ST_EXISTS, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_CREATE, 4'd15, NO_OWNER, 1'b1,
                              mtx_pkg::ST_OK, 1'b0));
    // all-ones pid matches the no-owner code of a never-locked slot
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd15, NO_OWNER, 1'b1,
                              mtx_pkg::ST_OK, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd0, 16'h0005, 1'b1,
                              mtx_pkg::ST_NOT_OWNER, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd0, 16'hAAAA, 1'b1,
                              mtx_pkg::ST_OK, 1'b1));
    // owner queues behind itself, then fill the queue
    dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd0, 16'hAAAA, 1'b0,
                              mtx_pkg::ST_OK, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd0, 16'h5555, 1'b0,
                              mtx_pkg::ST_OK, 1'b0));
    for (int i = 0; i < 6; i++) begin
      dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd0, 16'(16'h0100 + i), 1'b0,
                                mtx_pkg::ST_OK, 1'b0));
    end
    dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd0, 16'h1234, 1'b1,
                              mtx_pkg::ST_FULL, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd0, 16'h5555, 1'b1,
                              mtx_pkg::ST_NOT_OWNER, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd0, 16'hAAAA, 1'b0,
                              mtx_pkg::ST_OK, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd0, 16'hAAAA, 1'b0,
                              mtx_pkg::ST_OK, 1'b0));
    // terminate drops waiters silently
    dir_rows.push_back(mk_row(mtx_pkg::CMD_TERM, 4'd0, 16'h0007, 1'b1,
                              mtx_pkg::ST_OK, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd0, 16'h0001, 1'b1,
                              mtx_pkg::ST_MISSING, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd15, 16'h0000, 1'b1,
                              mtx_pkg::ST_NOT_OWNER, 1'b0));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_LOCK, 4'd15, 16'h0042, 1'b1,
                              mtx_pkg::ST_OK, 1'b1));
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd15, 16'h0042, 1'b1,
                              mtx_pkg::ST_OK, 1'b0));
    // unlock of a free mutex by its previous owner
    dir_rows.push_back(mk_row(mtx_pkg::CMD_UNLOCK, 4'd15, 16'h0042, 1'b1,
                              mtx_pkg::ST_OK, 1'b0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) issue_cmd(dir_rows[i].cmd, dir_rows[i].pinned, dir_rows[i].rsp);
    // hold off until every reply is back
    drain_replies();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < 206; n++) issue_cmd(pick_random_cmd(), 1'b0, '0);
      drain_replies();
    end

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
